// ===== hw/rtl/tcs_pkg.sv =====
`default_nettype none

package tcs_pkg;

  // Block-wide sizes
  localparam int unsigned MaxSegBytesDef = 1024;
  localparam int unsigned PktHdrBytes    = 6;
  localparam int unsigned LenHiIdx       = 4;  // packet header byte holding length[15:8]
  localparam int unsigned LenLoIdx       = 5;  // packet header byte holding length[7:0]

  localparam int unsigned OffW  = 10;
  localparam int unsigned LenW  = 10;
  localparam int unsigned PlenW = 17;

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    SEQ_CONT  = 2'd0,
    SEQ_FIRST = 2'd1,
    SEQ_LAST  = 2'd2,
    SEQ_UNSEG = 2'd3
  } tcs_seq_e;

  typedef enum logic {
    RK_DESC   = 1'b0,
    RK_STATUS = 1'b1
  } tcs_kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_DATA     = 3'd1,
    ST_FIRST_SHORT = 3'd2,
    ST_FIRST_WHOLE = 3'd3,
    ST_HDR_CUT     = 3'd4,
    ST_PKT_CUT     = 3'd5,
    ST_TOO_LONG    = 3'd6
  } tcs_status_e;

  typedef struct packed {
    tcs_kind_e         kind;
    logic [5:0]        channel_id;
    logic [1:0]        seq_flag;
    logic              opens_pkt;
    logic              closes_pkt;
    logic [OffW-1:0]   part_offset;
    logic [LenW-1:0]   part_length;
    logic [PlenW-1:0]  packet_length;
    tcs_status_e       status;
    logic              last_result;
  } tcs_result_t;

  // Zero, one or two results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0]  n;
    tcs_result_t r0;
    tcs_result_t r1;
  } tcs_push_t;

  typedef struct packed {
    logic [FifoCntW-1:0] count;
    logic                room;   // space for two more results
  } tcs_fifo_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcs_seg_parser.sv =====
`default_nettype none

module tcs_seg_parser
  import tcs_pkg::*;
#(
  parameter int unsigned MAX_SEG_BYTES = MaxSegBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] seg_byte_i,
  input  wire logic       seg_last_i,
  output tcs_push_t       push_o
);

  localparam int unsigned CntW = $clog2(MAX_SEG_BYTES);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEG_BYTES - 1);

  logic              in_seg_q, in_seg_d;
  tcs_seq_e          flag_q, flag_d;
  logic [5:0]        chan_q, chan_d;
  logic [CntW-1:0]   dcnt_q, dcnt_d;
  logic [CntW-1:0]   pstart_q, pstart_d;
  logic [2:0]        hcnt_q, hcnt_d;
  logic [7:0]        lenhi_q, lenhi_d;
  logic [PlenW-1:0]  ptotal_q, ptotal_d;
  logic              toolong_q, toolong_d;

  logic              desc_a, desc_b;
  tcs_result_t       res_a, res_b, res_st;
  tcs_status_e       st;
  logic [PlenW-1:0]  span;

  function automatic tcs_result_t mk_res(tcs_kind_e kind, tcs_seq_e flag, logic [5:0] chan,
                                         logic sp, logic ep, logic [OffW-1:0] off,
                                         logic [LenW-1:0] len, logic [PlenW-1:0] plen,
                                         tcs_status_e s, logic last);
    tcs_result_t r;
    r.kind          = kind;
    r.channel_id    = chan;
    r.seq_flag      = flag;
    r.opens_pkt     = sp;
    r.closes_pkt    = ep;
    r.part_offset   = off;
    r.part_length   = len;
    r.packet_length = plen;
    r.status        = s;
    r.last_result   = last;
    return r;
  endfunction

  assign span = PlenW'(dcnt_q) - PlenW'(pstart_q) + PlenW'(1);

  always_comb begin
    in_seg_d  = in_seg_q;
    flag_d    = flag_q;
    chan_d    = chan_q;
    dcnt_d    = dcnt_q;
    pstart_d  = pstart_q;
    hcnt_d    = hcnt_q;
    lenhi_d   = lenhi_q;
    ptotal_d  = ptotal_q;
    toolong_d = toolong_q;
    desc_a    = 1'b0;
    desc_b    = 1'b0;
    st        = ST_OK;
    res_a     = '0;
    res_b     = '0;
    res_st    = '0;
    push_o    = '0;

    if (accept_i) begin
      if (!in_seg_q) begin
        // header byte opens a new segment
        flag_d    = tcs_seq_e'(seg_byte_i[7:6]);
        chan_d    = seg_byte_i[5:0];
        dcnt_d    = '0;
        pstart_d  = '0;
        hcnt_d    = '0;
        lenhi_d   = '0;
        ptotal_d  = '0;
        toolong_d = 1'b0;
        if (seg_last_i) begin
          push_o.n  = 2'd1;
          push_o.r0 = mk_res(RK_STATUS, flag_d, chan_d, 1'b0, 1'b0, '0, '0, '0,
                             ST_NO_DATA, 1'b1);
        end else begin
          in_seg_d = 1'b1;
        end
      end else begin
        if (dcnt_q >= MaxCnt) begin
          toolong_d = 1'b1;
        end else begin
          dcnt_d = dcnt_q + CntW'(1);
          if (!toolong_q && (flag_q == SEQ_UNSEG || flag_q == SEQ_FIRST)) begin
            if (hcnt_q < 3'(PktHdrBytes)) begin
              if (hcnt_q == 3'd0) pstart_d = dcnt_q;
              if (hcnt_q == 3'(LenHiIdx)) lenhi_d = seg_byte_i;
              if (hcnt_q == 3'(LenLoIdx)) begin
                ptotal_d = PlenW'(PktHdrBytes + 1) + PlenW'({lenhi_q, seg_byte_i});
              end
              hcnt_d = hcnt_q + 3'd1;
            end else if (flag_q == SEQ_UNSEG && span == ptotal_q) begin
              desc_a = 1'b1;
              hcnt_d = 3'd0;
            end
          end
        end

        res_a = mk_res(RK_DESC, flag_q, chan_q, 1'b1, 1'b1, OffW'(pstart_q),
                       LenW'(ptotal_q), ptotal_q, ST_OK, !seg_last_i);

        if (seg_last_i) begin
          if (flag_q == SEQ_UNSEG) begin
            if (toolong_d)                       st = ST_TOO_LONG;
            else if (hcnt_d == 3'd0)             st = ST_OK;
            else if (hcnt_d < 3'(PktHdrBytes))   st = ST_HDR_CUT;
            else                                 st = ST_PKT_CUT;
          end else if (toolong_d) begin
            st = ST_TOO_LONG;
          end else if (flag_q == SEQ_FIRST) begin
            if (dcnt_d < CntW'(PktHdrBytes)) begin
              st = ST_FIRST_SHORT;
            end else if (ptotal_d <= PlenW'(dcnt_d)) begin
              st = ST_FIRST_WHOLE;
            end else begin
              desc_b = 1'b1;
              res_b  = mk_res(RK_DESC, flag_q, chan_q, 1'b1, 1'b0, '0, LenW'(dcnt_d),
                              ptotal_d, ST_OK, 1'b0);
            end
          end else begin
            desc_b = 1'b1;
            res_b  = mk_res(RK_DESC, flag_q, chan_q, 1'b0, flag_q == SEQ_LAST, '0,
                            LenW'(dcnt_d), '0, ST_OK, 1'b0);
          end
          res_st = mk_res(RK_STATUS, flag_q, chan_q, 1'b0, 1'b0, '0, LenW'(dcnt_d), '0,
                          st, 1'b1);
          // segment done
          in_seg_d  = 1'b0;
          dcnt_d    = '0;
          pstart_d  = '0;
          hcnt_d    = '0;
          lenhi_d   = '0;
          ptotal_d  = '0;
          toolong_d = 1'b0;
        end

        if (desc_a || desc_b) begin
          push_o.r0 = desc_a ? res_a : res_b;
          push_o.r1 = res_st;
          push_o.n  = seg_last_i ? 2'd2 : 2'd1;
        end else if (seg_last_i) begin
          push_o.r0 = res_st;
          push_o.n  = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seg_q  <= 1'b0;
      flag_q    <= SEQ_CONT;
      chan_q    <= '0;
      dcnt_q    <= '0;
      pstart_q  <= '0;
      hcnt_q    <= '0;
      lenhi_q   <= '0;
      ptotal_q  <= '0;
      toolong_q <= 1'b0;
    end else begin
      in_seg_q  <= in_seg_d;
      flag_q    <= flag_d;
      chan_q    <= chan_d;
      dcnt_q    <= dcnt_d;
      pstart_q  <= pstart_d;
      hcnt_q    <= hcnt_d;
      lenhi_q   <= lenhi_d;
      ptotal_q  <= ptotal_d;
      toolong_q <= toolong_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcs_result_fifo.sv =====
`default_nettype none

module tcs_result_fifo
  import tcs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire tcs_push_t push_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output tcs_result_t out_res_o,
  output tcs_fifo_stat_t stat_o
);

  tcs_result_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, wptr_d;
  logic [FifoPtrW-1:0]   rptr_q, rptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoPtrW-1:0]   wptr_nxt;
  logic                  pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign wptr_nxt    = wptr_q + FifoPtrW'(1);
  assign wptr_d      = wptr_q + FifoPtrW'(push_i.n);
  assign rptr_d      = pop ? rptr_q + FifoPtrW'(1) : rptr_q;
  assign cnt_d       = cnt_q + FifoCntW'(push_i.n) - FifoCntW'(pop);

  assign out_valid_o  = (cnt_q != '0);
  assign out_res_o    = mem_q[rptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.room  = (cnt_q <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wptr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tc_segment_packet_splitter_unit.sv =====
`default_nettype none
// Telecommand segment splitter.
// Input channel: one segment byte per transaction (seg_byte_i, seg_last_i),
// header byte first, seg_last_i on the final byte. A transaction completes
// on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: result transactions (part descriptors and one status per
// segment) under out_valid_o / out_stall_i; last_result_o marks the final
// result caused by one input byte.
// Results are registered: each result is written into the result queue on
// the edge that takes the byte causing it; a second result from the same
// byte is queued directly behind it.
// Throughput: one byte per cycle. Each byte gives at most two results, which
// go into a 4-entry result queue; in_stall_o rises while the queue holds
// more than two results, so the output drain rate sets the input rate when
// the receiver stalls or a byte produces two results.
// Receiver stall: queued results hold on the output unchanged until taken.
// Reset: asynchronous, active low; the queue empties and the parser waits
// for a header byte. No clearing pass is needed.
module tc_segment_packet_splitter_unit
  import tcs_pkg::*;
#(
  parameter int unsigned MAX_SEG_BYTES = MaxSegBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   seg_byte_i,
  input  wire logic         seg_last_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              result_kind_o,
  output logic [5:0]        channel_id_o,
  output logic [1:0]        seq_flag_o,
  output logic              opens_pkt_o,
  output logic              closes_pkt_o,
  output logic [OffW-1:0]   part_offset_o,
  output logic [LenW-1:0]   part_length_o,
  output logic [PlenW-1:0]  packet_length_o,
  output logic [2:0]        status_o,
  output logic              last_result_o
);

  logic           accept;
  tcs_push_t      push;
  tcs_result_t    res;
  tcs_fifo_stat_t fstat;

  // Take a byte only when the queue can absorb both results it may cause
  assign in_stall_o = !fstat.room;
  assign accept     = in_valid_i && !in_stall_o;

  tcs_seg_parser #(
    .MAX_SEG_BYTES(MAX_SEG_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .seg_byte_i (seg_byte_i),
    .seg_last_i (seg_last_i),
    .push_o     (push)
  );

  tcs_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res),
    .stat_o      (fstat)
  );

  assign result_kind_o   = res.kind;
  assign channel_id_o    = res.channel_id;
  assign seq_flag_o      = res.seq_flag;
  assign opens_pkt_o     = res.opens_pkt;
  assign closes_pkt_o    = res.closes_pkt;
  assign part_offset_o   = res.part_offset;
  assign part_length_o   = res.part_length;
  assign packet_length_o = res.packet_length;
  assign status_o        = res.status;
  assign last_result_o   = res.last_result;

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> (int'(fstat.count) + int'(push.n) <= FifoDepth))
    else $error("result queue overflow");

  // Results come only from accepted bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> (push.n == 2'd0))
    else $error("result without accepted byte");

  // A status result always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == RK_STATUS) |-> last_result_o)
    else $error("status result not marked last");

  // Descriptors carry no error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == RK_DESC) |-> (status_o == ST_OK))
    else $error("descriptor with error status");

endmodule

`default_nettype wire
